>>> src/mpct_pkg.sv
// package: shared types, constants and a helper function of the mouse cursor tracker
package mpct_pkg;

  localparam int PLAYER_COUNT_DEF = 4;
  localparam int CFG_W            = 12;
  localparam int CFG_IDX_W        = 2;
  localparam int COORD_W          = 20;
  localparam int SENS_W           = 6;
  localparam int DIV_STEPS        = 20;
  localparam int CNT_W            = $clog2(DIV_STEPS);
  localparam int RECIP_SHIFT      = 29;

  typedef logic [1:0]         player_t;
  typedef logic [7:0]         pkt_byte_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SENS_W-1:0]  sens_t;
  typedef logic [CFG_W-1:0]   cfg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_VIDEO_WIDTH   = 2'd2,
    REG_VIDEO_HEIGHT  = 2'd3
  } cfg_reg_t;

  localparam cfg_t SCREEN_W_RST = 12'd640;
  localparam cfg_t SCREEN_H_RST = 12'd480;
  localparam cfg_t VIDEO_W_RST  = 12'd640;
  localparam cfg_t VIDEO_H_RST  = 12'd480;

  localparam sens_t SENS_RST = 6'd10;
  localparam sens_t SENS_MIN = 6'd1;
  localparam sens_t SENS_MAX = 6'd50;

  // ceil(2^29 / 5), exact floor(t / 5) for t below 2^26
  localparam logic [26:0] RECIP_FIVE = 27'd107374183;

  // floor(128 * r / 5) for a remainder r of 0..4
  function automatic logic [6:0] frac_tab(input logic [2:0] r);
    logic [6:0] v;
    case (r)
      3'd0:    v = 7'd0;
      3'd1:    v = 7'd25;
      3'd2:    v = 7'd51;
      3'd3:    v = 7'd76;
      3'd4:    v = 7'd102;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/mpct_in_if.sv
// interface: packet input channel
interface mpct_in_if;
  import mpct_pkg::*;

  logic      valid;
  logic      ready;
  player_t   player;
  pkt_byte_t ctrl_byte;
  pkt_byte_t dx_byte;
  pkt_byte_t dy_byte;
  pkt_byte_t wheel_byte;

  modport source (output valid, output player, output ctrl_byte, output dx_byte,
                  output dy_byte, output wheel_byte, input ready);
  modport sink   (input valid, input player, input ctrl_byte, input dx_byte,
                  input dy_byte, input wheel_byte, output ready);
endinterface

>>> src/mpct_out_if.sv
// interface: cursor result channel
interface mpct_out_if;
  import mpct_pkg::*;

  logic    valid;
  logic    ready;
  player_t player_out;
  coord_t  cursor_x;
  coord_t  cursor_y;
  logic    button_down;
  logic    press_edge;
  sens_t   sensitivity_level;
  logic    sensitivity_changed;

  modport source (output valid, output player_out, output cursor_x, output cursor_y,
                  output button_down, output press_edge, output sensitivity_level,
                  output sensitivity_changed, input ready);
  modport sink   (input valid, input player_out, input cursor_x, input cursor_y,
                  input button_down, input press_edge, input sensitivity_level,
                  input sensitivity_changed, output ready);
endinterface

>>> src/mouse_packet_cursor_tracker.sv
// top level: per-player wheel-mouse packet decoder and cursor tracker
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+------------------------------------------
//  in_ch    | in  | valid / ready        | player, ctrl_byte, dx_byte, dy_byte, wheel_byte
//  out_ch   | out | valid / ready        | player_out, cursor_x/y, buttons, sensitivity
//  cfg_*    | in  | cfg_wr_en, no stall  | cfg_index, cfg_wr_data
//
// a packet for a valid player runs from acceptance to the raising of out_ch.valid through,
// per axis, one multiply, 20 steps of the shared restoring divider, two more multiplies,
// a delta and a clamp step, then ST_FIN loads the output register once it is free.
// a packet for a player beyond the count goes straight from acceptance to ST_FIN.
// in_ch is ready only while the sequencer is idle; a result waiting in the output
// register does not block the next transaction until its own result is due.
// synchronous active-low reset restores the configuration registers, the sequencer, the
// output valid flag, and the positions, sensitivity and button state of every player.
module mouse_packet_cursor_tracker #(
  parameter int PLAYER_COUNT = mpct_pkg::PLAYER_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mpct_in_if.sink                       in_ch,
  mpct_out_if.source                    out_ch,
  input  logic                          cfg_wr_en,
  input  logic [mpct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpct_pkg::CFG_W-1:0]     cfg_wr_data
);
  import mpct_pkg::*;

  localparam int IDX_W = (PLAYER_COUNT > 1) ? $clog2(PLAYER_COUNT) : 1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL1 = 8'b0000_0010,
    ST_DIV  = 8'b0000_0100,
    ST_MUL2 = 8'b0000_1000,
    ST_MUL3 = 8'b0001_0000,
    ST_DLT  = 8'b0010_0000,
    ST_UPD  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

  state_t             state_r;
  logic               axis_r;
  player_t            player_r;
  logic [IDX_W-1:0]   idx_r;
  logic               ok_r;
  logic               sx_r, sy_r;
  pkt_byte_t          dx_r, dy_r;
  logic               down_r, just_r, changed_r;
  sens_t              sens_r;
  logic [CNT_W-1:0]   cnt_r;
  coord_t             dq_r;
  cfg_t               rem_r;
  logic [52:0]        prod_r;
  logic [25:0]        t_r;
  logic [30:0]        dmag_r;

  cfg_t scr_w_r, scr_h_r, vid_w_r, vid_h_r;

  coord_t pos_x_r    [PLAYER_COUNT];
  coord_t pos_y_r    [PLAYER_COUNT];
  sens_t  sens_str_r [PLAYER_COUNT];
  logic   held_r     [PLAYER_COUNT];

  logic    out_valid_r;
  player_t out_player_r;
  coord_t  out_x_r, out_y_r;
  logic    out_down_r, out_just_r, out_changed_r;
  sens_t   out_sens_r;

  // acceptance side
  logic               in_acc;
  logic [IDX_W-1:0]   idx_in;
  logic               ok_in;
  sens_t              sens_cur;
  logic               held_cur;
  logic signed [9:0]  dz;
  logic signed [9:0]  sens_sum;
  sens_t              sens_nxt;
  logic               wheel_nz;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign idx_in   = IDX_W'(in_ch.player);
  assign ok_in    = (32'(in_ch.player) < PLAYER_COUNT);
  assign wheel_nz = (in_ch.wheel_byte != 8'd0);

  always_comb begin
    sens_cur = ok_in ? sens_str_r[idx_in] : SENS_RST;
    held_cur = ok_in ? held_r[idx_in] : 1'b0;
    dz       = (in_ch.wheel_byte[7:3] != 5'd0) ? {2'b11, in_ch.wheel_byte}
                                               : {2'b00, in_ch.wheel_byte};
    sens_sum = $signed({4'b0000, sens_cur}) + dz;
    if (!wheel_nz) begin
      sens_nxt = sens_cur;
    end else if (sens_sum < $signed({4'b0000, SENS_MIN})) begin
      sens_nxt = SENS_MIN;
    end else if (sens_sum > $signed({4'b0000, SENS_MAX})) begin
      sens_nxt = SENS_MAX;
    end else begin
      sens_nxt = sens_sum[SENS_W-1:0];
    end
  end

  // per-axis operand selection
  logic              d_sign;
  logic [8:0]        d9, d_mag;
  cfg_t              scr, vid, vid_eff;
  coord_t            pos_cur, lim;

  always_comb begin
    d_sign  = axis_r ? sy_r : sx_r;
    d9      = {d_sign, (axis_r ? dy_r : dx_r)};
    d_mag   = d_sign ? (~d9 + 9'd1) : d9;
    scr     = axis_r ? scr_h_r : scr_w_r;
    vid     = axis_r ? vid_h_r : vid_w_r;
    vid_eff = (vid == '0) ? 12'd1 : vid;
    pos_cur = axis_r ? pos_y_r[idx_r] : pos_x_r[idx_r];
    lim     = {scr, 8'h00};
  end

  // shared multiplier
  logic [25:0] mul_a;
  logic [26:0] mul_b;
  logic [52:0] mul_p;

  always_comb begin
    case (state_r)
      ST_MUL1: begin
        mul_a = 26'(d_mag);
        mul_b = 27'(scr);
      end
      ST_MUL2: begin
        mul_a = 26'(dq_r);
        mul_b = 27'(sens_r);
      end
      default: begin
        mul_a = prod_r[25:0];
        mul_b = RECIP_FIVE;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // restoring divider step
  logic [12:0] rem_sh, rem_sub;
  logic        rem_ge;

  assign rem_sh  = {rem_r, dq_r[COORD_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, vid_eff});
  assign rem_sub = rem_sh - {1'b0, vid_eff};

  // divide by ten: t * 256 / 10 = 128 * (t / 5) + floor(128 * (t % 5) / 5)
  logic [23:0] quo5;
  logic [25:0] five_q, rem5_full;
  logic [30:0] dmag_nxt;

  always_comb begin
    quo5      = prod_r[52:RECIP_SHIFT];
    five_q    = {quo5, 2'b00} + 26'(quo5);
    rem5_full = t_r - five_q;
    dmag_nxt  = {quo5, 7'h00} + 31'(frac_tab(rem5_full[2:0]));
  end

  // position update and clamp
  logic signed [32:0] dlt_s, sum_s;
  coord_t             pos_nxt;

  always_comb begin
    dlt_s = $signed({2'b00, dmag_r});
    if (d_sign) begin
      dlt_s = -dlt_s;
    end
    sum_s = $signed({13'h0000, pos_cur}) + dlt_s;
    if (sum_s < 33'sd0) begin
      pos_nxt = '0;
    end else if (sum_s > $signed({13'h0000, lim})) begin
      pos_nxt = lim;
    end else begin
      pos_nxt = sum_s[COORD_W-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SCREEN_W_RST;
      scr_h_r <= SCREEN_H_RST;
      vid_w_r <= VIDEO_W_RST;
      vid_h_r <= VIDEO_H_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  scr_w_r <= cfg_wr_data;
        REG_SCREEN_HEIGHT: scr_h_r <= cfg_wr_data;
        REG_VIDEO_WIDTH:   vid_w_r <= cfg_wr_data;
        REG_VIDEO_HEIGHT:  vid_h_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // sequencer
  logic out_load;
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            axis_r  <= 1'b0;
            state_r <= ok_in ? ST_MUL1 : ST_FIN;
          end
        end
        ST_MUL1: state_r <= ST_DIV;
        ST_DIV: begin
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_r <= ST_MUL2;
          end
        end
        ST_MUL2: state_r <= ST_MUL3;
        ST_MUL3: state_r <= ST_DLT;
        ST_DLT:  state_r <= ST_UPD;
        ST_UPD: begin
          if (axis_r) begin
            state_r <= ST_FIN;
          end else begin
            axis_r  <= 1'b1;
            state_r <= ST_MUL1;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      player_r  <= in_ch.player;
      idx_r     <= idx_in;
      ok_r      <= ok_in;
      sx_r      <= in_ch.ctrl_byte[4];
      sy_r      <= in_ch.ctrl_byte[5];
      dx_r      <= in_ch.dx_byte;
      dy_r      <= in_ch.dy_byte;
      down_r    <= in_ch.ctrl_byte[0];
      just_r    <= in_ch.ctrl_byte[0] && !held_cur;
      sens_r    <= sens_nxt;
      changed_r <= wheel_nz;
    end
    case (state_r)
      ST_MUL1: begin
        dq_r  <= mul_p[COORD_W-1:0];
        rem_r <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= rem_ge ? rem_sub[11:0] : rem_sh[11:0];
        dq_r  <= {dq_r[COORD_W-2:0], rem_ge};
        cnt_r <= cnt_r + 1'b1;
      end
      ST_MUL2: prod_r <= mul_p;
      ST_MUL3: begin
        prod_r <= mul_p;
        t_r    <= prod_r[25:0];
      end
      ST_DLT:  dmag_r <= dmag_nxt;
      default: ;
    endcase
  end

  // per-player state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLAYER_COUNT; i++) begin
        pos_x_r[i]    <= '0;
        pos_y_r[i]    <= '0;
        sens_str_r[i] <= SENS_RST;
        held_r[i]     <= 1'b0;
      end
    end else begin
      if (in_acc && ok_in) begin
        sens_str_r[idx_in] <= sens_nxt;
        held_r[idx_in]     <= in_ch.ctrl_byte[0];
      end
      if (state_r == ST_UPD && ok_r) begin
        if (axis_r) begin
          pos_y_r[idx_r] <= pos_nxt;
        end else begin
          pos_x_r[idx_r] <= pos_nxt;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_player_r  <= player_r;
      out_x_r       <= ok_r ? pos_x_r[idx_r] : '0;
      out_y_r       <= ok_r ? pos_y_r[idx_r] : '0;
      out_down_r    <= ok_r && down_r;
      out_just_r    <= ok_r && just_r;
      out_sens_r    <= ok_r ? sens_r : '0;
      out_changed_r <= ok_r && changed_r;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.player_out          = out_player_r;
  assign out_ch.cursor_x            = out_x_r;
  assign out_ch.cursor_y            = out_y_r;
  assign out_ch.button_down         = out_down_r;
  assign out_ch.press_edge          = out_just_r;
  assign out_ch.sensitivity_level   = out_sens_r;
  assign out_ch.sensitivity_changed = out_changed_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input taken while a packet is in flight");

  a_sens_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && ok_r) |-> (sens_r >= SENS_MIN && sens_r <= SENS_MAX))
    else $error("sensitivity out of range");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the final step");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r < CNT_W'(DIV_STEPS)))
    else $error("divider step count overrun");

endmodule
